// ===== hw/rtl/lfs_pkg.sv =====
// Shared types, constants and helpers for the lazy flip segment tree block.
// No dependencies; lfs_node_unit and the top level import this package.
`timescale 1ns / 1ps

package lfs_pkg;

    localparam int unsigned LEAVES_DEF  = 1024;
    localparam logic [29:0] MIRROR_BASE = 30'd1000000007;

    // operation codes of the input beat
    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_LOAD    = 2'd1,
        OP_REFLECT = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  position;
        logic [29:0] element_value;
        logic [9:0]  range_first;
        logic [9:0]  range_last;
    } t_in;

    typedef struct packed {
        logic [10:0] max_position;
        logic [29:0] max_value;
    } t_out;

    // one tree node as stored in the node RAM
    typedef struct packed {
        logic        occ;
        logic        pend;
        logic [29:0] bv;
        logic [9:0]  bp;
        logic [29:0] mv;
        logic [9:0]  mp;
    } t_node;

    // node operations carried out by the node unit
    typedef enum logic [2:0] {
        NK_CLEAR,
        NK_PUSH,
        NK_PULL,
        NK_APPLY,
        NK_LEAF,
        NK_ROOT
    } t_nkind;

    typedef struct packed {
        logic   valid;
        t_nkind kind;
    } t_node_cmd;

    typedef struct packed {
        logic  done;
        t_node root;
    } t_node_sts;

    // node unit phases
    typedef enum logic [3:0] {
        NP_IDLE,
        NP_CHK,
        NP_W0,
        NP_W1,
        NP_W2,
        NP_CMPB,
        NP_CMPM,
        NP_APPLY,
        NP_ROOT,
        NP_CLR
    } t_nph;

    // top level sequencer states
    typedef enum logic [2:0] {
        SQ_CLEAR,
        SQ_IDLE,
        SQ_DOWN,
        SQ_LEAF,
        SQ_SPAN,
        SQ_UP,
        SQ_ROOT,
        SQ_OUT
    } t_seq;

    // reflect a whole node: swap the two bests, toggle the pending mark
    function automatic t_node flip_node(input t_node n);
        t_node f;
        f      = n;
        f.bv   = n.mv;
        f.bp   = n.mp;
        f.mv   = n.bv;
        f.mp   = n.bp;
        f.pend = ~n.pend;
        return f;
    endfunction

endpackage

// ===== hw/rtl/lfs_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lfs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, hold data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

// ===== hw/rtl/lfs_cmp.sv =====
// Shared compare unit: picks the left or right child entry for a merge.
// No dependencies.
`timescale 1ns / 1ps

module lfs_cmp (
    input  logic        i_occ_l,
    input  logic        i_occ_r,
    input  logic [29:0] i_val_l,
    input  logic [9:0]  i_pos_l,
    input  logic [29:0] i_val_r,
    input  logic [9:0]  i_pos_r,
    output logic        o_use_l
);

    logic w_beats;

    // larger value wins, smaller position on ties
    assign w_beats = (i_val_l > i_val_r) || ((i_val_l == i_val_r) && (i_pos_l <= i_pos_r));

    // an empty child never wins over an occupied one
    assign o_use_l = !i_occ_r || (i_occ_l && w_beats);

endmodule

// ===== hw/rtl/lfs_node_unit.sv =====
// Node unit: push, pull, flip, leaf write, root read and clear sweep on the node RAM.
// Depends on lfs_pkg, lfs_ram and lfs_cmp.
`timescale 1ns / 1ps

module lfs_node_unit #(
    parameter int unsigned DEPTH = 2 * lfs_pkg::LEAVES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lfs_pkg::t_node_cmd       i_cmd,
    input  logic [$clog2(DEPTH)-1:0] i_idx,
    input  lfs_pkg::t_node           i_leaf,
    output lfs_pkg::t_node_sts       o_sts
);

    import lfs_pkg::*;

    localparam int unsigned IDX_W = $clog2(DEPTH);

    t_nph             r_ph;
    t_nph             n_ph;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] n_cnt;
    t_node            r_self;
    logic             r_useb;

    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_node            w_wdata;
    logic             w_re;
    logic [IDX_W-1:0] w_raddr_a;
    logic [IDX_W-1:0] w_raddr_b;
    logic [$bits(t_node)-1:0] w_rd_a_bits;
    logic [$bits(t_node)-1:0] w_rd_b_bits;
    t_node            w_rd_a;
    t_node            w_rd_b;
    logic             w_done;
    logic             w_use_l;
    logic             w_cmp_mirror;
    logic [IDX_W-1:0] w_lchild;
    logic [IDX_W-1:0] w_rchild;
    logic [IDX_W-1:0] w_cmd_l;
    logic [IDX_W-1:0] w_cmd_r;
    t_node            w_merged;

    assign w_rd_a = t_node'(w_rd_a_bits);
    assign w_rd_b = t_node'(w_rd_b_bits);

    // child addresses of the latched node and of the incoming command
    assign w_lchild = IDX_W'({r_idx, 1'b0});
    assign w_rchild = IDX_W'({r_idx, 1'b1});
    assign w_cmd_l  = IDX_W'({i_idx, 1'b0});
    assign w_cmd_r  = IDX_W'({i_idx, 1'b1});

    lfs_ram #(
        .WIDTH ($bits(t_node)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_re),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd_a_bits),
        .o_rdata_b (w_rd_b_bits)
    );

    // one compare unit for both the best and the mirror merge
    assign w_cmp_mirror = (r_ph == NP_CMPM);

    lfs_cmp u_cmp (
        .i_occ_l (w_rd_a.occ),
        .i_occ_r (w_rd_b.occ),
        .i_val_l (w_cmp_mirror ? w_rd_a.mv : w_rd_a.bv),
        .i_pos_l (w_cmp_mirror ? w_rd_a.mp : w_rd_a.bp),
        .i_val_r (w_cmp_mirror ? w_rd_b.mv : w_rd_b.bv),
        .i_pos_r (w_cmp_mirror ? w_rd_b.mp : w_rd_b.bp),
        .o_use_l (w_use_l)
    );

    // merged parent from the two children
    always_comb begin
        w_merged      = '0;
        w_merged.occ  = w_rd_a.occ | w_rd_b.occ;
        w_merged.pend = 1'b0;
        w_merged.bv   = r_useb ? w_rd_a.bv : w_rd_b.bv;
        w_merged.bp   = r_useb ? w_rd_a.bp : w_rd_b.bp;
        w_merged.mv   = w_use_l ? w_rd_a.mv : w_rd_b.mv;
        w_merged.mp   = w_use_l ? w_rd_a.mp : w_rd_b.mp;
    end

    // next phase
    always_comb begin
        n_ph = r_ph;
        unique case (r_ph)
            NP_IDLE: begin
                if (i_cmd.valid) begin
                    unique case (i_cmd.kind)
                        NK_CLEAR: n_ph = NP_CLR;
                        NK_PUSH:  n_ph = NP_CHK;
                        NK_PULL:  n_ph = NP_CMPB;
                        NK_APPLY: n_ph = NP_APPLY;
                        NK_ROOT:  n_ph = NP_ROOT;
                        default:  n_ph = NP_IDLE;
                    endcase
                end
            end
            NP_CHK:   n_ph = w_rd_a.pend ? NP_W0 : NP_IDLE;
            NP_W0:    n_ph = NP_W1;
            NP_W1:    n_ph = NP_W2;
            NP_W2:    n_ph = NP_IDLE;
            NP_CMPB:  n_ph = NP_CMPM;
            NP_CMPM:  n_ph = NP_IDLE;
            NP_APPLY: n_ph = NP_IDLE;
            NP_ROOT:  n_ph = NP_IDLE;
            NP_CLR:   n_ph = (r_cnt == IDX_W'(DEPTH - 1)) ? NP_IDLE : NP_CLR;
            default:  n_ph = NP_IDLE;
        endcase
    end

    // RAM control and completion per phase
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_idx;
        w_wdata   = '0;
        w_re      = 1'b0;
        w_raddr_a = w_lchild;
        w_raddr_b = w_rchild;
        w_done    = 1'b0;
        n_cnt     = r_cnt;
        unique case (r_ph)
            NP_IDLE: begin
                if (i_cmd.valid) begin
                    unique case (i_cmd.kind)
                        NK_CLEAR: n_cnt = '0;
                        NK_PUSH: begin
                            w_re      = 1'b1;
                            w_raddr_a = i_idx;
                        end
                        NK_PULL: begin
                            w_re      = 1'b1;
                            w_raddr_a = w_cmd_l;
                            w_raddr_b = w_cmd_r;
                        end
                        NK_APPLY: begin
                            w_re      = 1'b1;
                            w_raddr_a = i_idx;
                        end
                        NK_LEAF: begin
                            w_we    = 1'b1;
                            w_waddr = i_idx;
                            w_wdata = i_leaf;
                            w_done  = 1'b1;
                        end
                        NK_ROOT: begin
                            w_re      = 1'b1;
                            w_raddr_a = IDX_W'(1);
                        end
                        default: w_done = 1'b0;
                    endcase
                end
            end
            NP_CHK: begin
                // nothing pending: the push is done
                if (w_rd_a.pend) begin
                    w_re = 1'b1;
                end else begin
                    w_done = 1'b1;
                end
            end
            NP_W0: begin
                w_we    = 1'b1;
                w_waddr = w_lchild;
                w_wdata = flip_node(w_rd_a);
            end
            NP_W1: begin
                w_we    = 1'b1;
                w_waddr = w_rchild;
                w_wdata = flip_node(w_rd_b);
            end
            NP_W2: begin
                w_we         = 1'b1;
                w_wdata      = r_self;
                w_wdata.pend = 1'b0;
                w_done       = 1'b1;
            end
            NP_CMPB: w_done = 1'b0;
            NP_CMPM: begin
                w_we    = 1'b1;
                w_wdata = w_merged;
                w_done  = 1'b1;
            end
            NP_APPLY: begin
                w_we    = 1'b1;
                w_wdata = flip_node(w_rd_a);
                w_done  = 1'b1;
            end
            NP_ROOT: w_done = 1'b1;
            NP_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt;
                n_cnt   = r_cnt + IDX_W'(1);
                w_done  = (r_cnt == IDX_W'(DEPTH - 1));
            end
            default: w_done = 1'b0;
        endcase
    end

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= NP_IDLE;
        end else begin
            r_ph <= n_ph;
        end
    end

    // operand registers
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        if (r_ph == NP_IDLE && i_cmd.valid) begin
            r_idx <= i_idx;
        end
        if (r_ph == NP_CHK) begin
            r_self <= w_rd_a;
        end
        if (r_ph == NP_CMPB) begin
            r_useb <= w_use_l;
        end
    end

    assign o_sts.done = w_done;
    assign o_sts.root = w_rd_a;

    // no write without a command in progress
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == NP_IDLE && !i_cmd.valid) |-> !w_we)
        else $error("node RAM written while idle");

    // a pending push always ends with the parent write
    a_push_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == NP_W0) |=> (r_ph == NP_W1) ##1 (r_ph == NP_W2))
        else $error("push write sequence broken");

    // the mirror merge always follows the best merge
    a_pull_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == NP_CMPM) |-> $past(r_ph == NP_CMPB))
        else $error("mirror merge without best merge");

endmodule

// ===== hw/rtl/lazy_flip_segment_tree_argmax.sv =====
// Lazy flip segment tree with argmax: one input beat at a time, o_ready low while it runs.
// With LOG = clog2(LEAVES), a load or reflect runs a down walk of 2*LOG steps, pushing pending
// flips on the boundary path nodes, and an up walk of 2*LOG steps that pulls them. Load adds a
// leaf write between the walks. Reflect adds a span walk between them (each step a shift, an
// end check or a flip), then a root read and the result beat, held until i_ready. A reflect
// with an empty range goes straight to the root read; a load past the last leaf is dropped.
// Reset and a clear beat sweep the 2*2^LOG node RAM, one entry a cycle, with o_ready low.
// Depends on lfs_pkg and lfs_node_unit.
`timescale 1ns / 1ps

module lazy_flip_segment_tree_argmax #(
    parameter int unsigned LEAVES = lfs_pkg::LEAVES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lfs_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output lfs_pkg::t_out o_res
);

    import lfs_pkg::*;

    localparam int unsigned LOG   = $clog2(LEAVES);
    localparam int unsigned P     = 1 << LOG;
    localparam int unsigned IDX_W = LOG + 1;
    localparam int unsigned PW    = ((LOG > 10) ? LOG : 10) + 2;
    localparam int unsigned LVL_W = $clog2(LOG + 1);

    t_seq             r_state;
    t_seq             n_state;
    logic [LVL_W-1:0] r_lvl;
    logic [LVL_W-1:0] n_lvl;
    logic             r_side;
    logic             n_side;
    logic             r_all;
    logic             n_all;
    logic [PW-1:0]    r_l;
    logic [PW-1:0]    n_l;
    logic [PW-1:0]    r_r;
    logic [PW-1:0]    n_r;
    logic [PW-1:0]    r_sl;
    logic [PW-1:0]    n_sl;
    logic [PW-1:0]    r_sr;
    logic [PW-1:0]    n_sr;
    logic             r_wait;
    t_node            r_leaf;
    t_node            n_leaf;
    t_out             r_res;

    t_node_cmd        w_cmd;
    t_node_sts        w_sts;
    logic [IDX_W-1:0] w_idx;
    logic             w_need;
    logic             w_step;
    logic             w_accept;
    logic [PW-1:0]    w_mask;
    logic             w_cond_l;
    logic             w_cond_r;
    logic             w_path_need;
    logic [IDX_W-1:0] w_path_idx;
    logic             w_span_go;
    logic [PW-1:0]    w_pos;
    logic [PW-1:0]    w_first;
    logic [PW-1:0]    w_last;
    logic [PW-1:0]    w_lim;
    logic [29:0]      w_val;
    logic             w_load_ok;
    logic             w_refl_ok;

    assign w_accept = i_valid && o_ready;

    // decode the input beat
    assign w_pos     = PW'(i_item.position);
    assign w_first   = PW'(i_item.range_first);
    assign w_lim     = PW'(LEAVES - 1);
    assign w_last    = (PW'(i_item.range_last) > w_lim) ? w_lim : PW'(i_item.range_last);
    assign w_val     = (i_item.element_value > MIRROR_BASE) ? MIRROR_BASE
                                                            : i_item.element_value;
    assign w_load_ok = (w_pos < PW'(LEAVES));
    assign w_refl_ok = (w_first <= w_last);

    // boundary path nodes at the current level
    assign w_mask      = (PW'(1) << r_lvl) - PW'(1);
    assign w_cond_l    = (r_l & w_mask) != '0;
    assign w_cond_r    = (r_r & w_mask) != '0;
    assign w_path_need = r_side ? (!r_all && w_cond_r) : (r_all || w_cond_l);
    assign w_path_idx  = r_side ? IDX_W'((r_r - PW'(1)) >> r_lvl) : IDX_W'(r_l >> r_lvl);
    assign w_span_go   = (r_sl < r_sr);

    // command to the node unit
    always_comb begin
        w_need    = 1'b0;
        w_idx     = w_path_idx;
        w_cmd     = '0;
        w_cmd.kind = NK_PUSH;
        unique case (r_state)
            SQ_CLEAR: begin
                w_need     = 1'b1;
                w_cmd.kind = NK_CLEAR;
            end
            SQ_DOWN: begin
                w_need     = w_path_need;
                w_cmd.kind = NK_PUSH;
            end
            SQ_LEAF: begin
                w_need     = 1'b1;
                w_cmd.kind = NK_LEAF;
                w_idx      = IDX_W'(r_l);
            end
            SQ_SPAN: begin
                w_need     = w_span_go && (r_sl[0] || r_sr[0]);
                w_cmd.kind = NK_APPLY;
                w_idx      = r_sl[0] ? IDX_W'(r_sl) : IDX_W'(r_sr - PW'(1));
            end
            SQ_UP: begin
                w_need     = w_path_need;
                w_cmd.kind = NK_PULL;
            end
            SQ_ROOT: begin
                w_need     = 1'b1;
                w_cmd.kind = NK_ROOT;
            end
            default: w_need = 1'b0;
        endcase
        w_cmd.valid = w_need && !r_wait;
    end

    assign w_step = w_need ? w_sts.done : 1'b1;

    lfs_node_unit #(
        .DEPTH (2 * P)
    ) u_node (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_idx   (w_idx),
        .i_leaf  (r_leaf),
        .o_sts   (w_sts)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SQ_CLEAR: if (w_step) n_state = SQ_IDLE;
            SQ_IDLE: begin
                if (w_accept) begin
                    unique case (t_op'(i_item.op))
                        OP_CLEAR:   n_state = SQ_CLEAR;
                        OP_LOAD:    n_state = w_load_ok ? SQ_DOWN : SQ_IDLE;
                        OP_REFLECT: n_state = w_refl_ok ? SQ_DOWN : SQ_ROOT;
                        default:    n_state = SQ_IDLE;
                    endcase
                end
            end
            SQ_DOWN: begin
                if (w_step && r_side && r_lvl == LVL_W'(1)) begin
                    n_state = r_all ? SQ_LEAF : SQ_SPAN;
                end
            end
            SQ_LEAF: if (w_step) n_state = SQ_UP;
            SQ_SPAN: if (!w_span_go) n_state = SQ_UP;
            SQ_UP: begin
                if (w_step && r_side && r_lvl == LVL_W'(LOG)) begin
                    n_state = r_all ? SQ_IDLE : SQ_ROOT;
                end
            end
            SQ_ROOT: if (w_step) n_state = SQ_OUT;
            SQ_OUT:  if (i_ready) n_state = SQ_IDLE;
            default: n_state = SQ_IDLE;
        endcase
    end

    // walk registers
    always_comb begin
        n_lvl  = r_lvl;
        n_side = r_side;
        n_all  = r_all;
        n_l    = r_l;
        n_r    = r_r;
        n_sl   = r_sl;
        n_sr   = r_sr;
        n_leaf = r_leaf;
        unique case (r_state)
            SQ_IDLE: begin
                n_lvl       = LVL_W'(LOG);
                n_side      = 1'b0;
                n_all       = (t_op'(i_item.op) == OP_LOAD);
                n_l         = (n_all ? w_pos : w_first) + PW'(P);
                n_r         = w_last + PW'(1) + PW'(P);
                n_sl        = n_l;
                n_sr        = n_r;
                n_leaf.occ  = 1'b1;
                n_leaf.pend = 1'b0;
                n_leaf.bv   = w_val;
                n_leaf.bp   = i_item.position;
                n_leaf.mv   = MIRROR_BASE - w_val;
                n_leaf.mp   = i_item.position;
            end
            SQ_DOWN: begin
                if (w_step) begin
                    n_side = ~r_side;
                    if (r_side) begin
                        n_lvl = (r_lvl == LVL_W'(1)) ? LVL_W'(1) : r_lvl - LVL_W'(1);
                    end
                end
            end
            SQ_LEAF: n_lvl = LVL_W'(1);
            SQ_SPAN: begin
                // take an odd left edge, then an odd right edge, else climb a level
                if (w_step && w_span_go) begin
                    if (r_sl[0]) begin
                        n_sl = r_sl + PW'(1);
                    end else if (r_sr[0]) begin
                        n_sr = r_sr - PW'(1);
                    end else begin
                        n_sl = r_sl >> 1;
                        n_sr = r_sr >> 1;
                    end
                end
                n_lvl  = LVL_W'(1);
                n_side = 1'b0;
            end
            SQ_UP: begin
                if (w_step) begin
                    n_side = ~r_side;
                    if (r_side && r_lvl != LVL_W'(LOG)) begin
                        n_lvl = r_lvl + LVL_W'(1);
                    end
                end
            end
            default: n_lvl = r_lvl;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_CLEAR;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_sts.done) begin
                r_wait <= 1'b0;
            end else if (w_cmd.valid) begin
                r_wait <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lvl  <= n_lvl;
        r_side <= n_side;
        r_all  <= n_all;
        r_l    <= n_l;
        r_r    <= n_r;
        r_sl   <= n_sl;
        r_sr   <= n_sr;
        r_leaf <= n_leaf;
        // capture the root into the result register
        if (r_state == SQ_ROOT && w_step) begin
            if (w_sts.root.occ) begin
                r_res.max_position <= {1'b0, w_sts.root.bp} + 11'd1;
                r_res.max_value    <= w_sts.root.bv;
            end else begin
                r_res <= '0;
            end
        end
    end

    assign o_ready = (r_state == SQ_IDLE);
    assign o_valid = (r_state == SQ_OUT);
    assign o_res   = r_res;

    // path walks stay within the tree levels
    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_DOWN || r_state == SQ_UP) |-> (r_lvl >= LVL_W'(1) && r_lvl <= LVL_W'(LOG)))
        else $error("tree level out of range");

    // a reported position is always a real leaf or the empty marker
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.max_position <= 11'(LEAVES) || 11'(LEAVES) == 11'd0))
        else $error("reported position past the last leaf");

    // no new node command while one is still in flight
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.valid |-> !r_wait)
        else $error("node command issued while waiting");

    // a result beat only follows a root read
    a_res_after_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == SQ_ROOT))
        else $error("result without root read");

endmodule
